// ----- hw/rtl/sgd_momentum_update_top_defines.svh -----
// assertion macros shared by the sgd momentum update rtl
// no dependencies; included by files that carry assertions
`ifndef SGD_MOMENTUM_UPDATE_TOP_DEFINES_SVH
`define SGD_MOMENTUM_UPDATE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SGDM_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgdm check failed");

// next-cycle implication, checked outside reset
`define SGDM_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgdm next-cycle check failed");

`endif

// ----- hw/rtl/sgdm_pkg.sv -----
// types, constants and arithmetic helpers for the sgd momentum update block
// no dependencies
`default_nettype none

package sgdm_pkg;

    localparam int unsigned IDX_W      = 10;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned COEF_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_NESTEROV = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]         elem_index;
        logic signed [DATA_W-1:0] weight_in;
        logic signed [DATA_W-1:0] grad_in;
        logic                     first_use;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight_out;
        logic signed [DATA_W-1:0] velocity_out;
    } t_out_item;

    typedef struct packed {
        logic [COEF_W-1:0] learn_rate;
        logic [COEF_W-1:0] momentum_factor;
        logic [COEF_W-1:0] decay_factor;
        logic              use_nesterov;
    } t_cfg;

    // q0.16 coefficient times q8.24 data, low 16 bits dropped (floor)
    function automatic logic signed [DATA_W-1:0] f_scale(
        input logic [COEF_W-1:0]         coef,
        input logic signed [DATA_W-1:0]  data
    );
        logic signed [COEF_W+DATA_W:0] prod;
        prod = $signed({1'b0, coef}) * data;
        return prod[COEF_W+DATA_W-1:COEF_W];
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [DATA_W:0] sum);
        logic signed [DATA_W-1:0] res;
        if (sum[DATA_W] != sum[DATA_W-1]) begin
            res = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res = sum[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_add_sat(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return f_sat({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sub_sat(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return f_sat({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sgd_momentum_update_top.sv -----
// top level of the sgd momentum update block: configuration registers, velocity store, datapath
// depends on sgdm_pkg, sgdm_vel_mem and sgdm_pipe
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_data (t_in_item)
// output    out        o_valid / i_stall    o_data (t_out_item)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one transaction per cycle unless stalled (output or clearing sweep), eight register stages
// a result is registered in stages s1 to s7 and then in the output register
// after reset the velocity store is swept to zero, input stalled meanwhile
// a stall on the output fills the empty stages first, then backs up to the input
// a velocity written by one element is forwarded to the next one at the same index
`default_nettype none

module sgd_momentum_update_top #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  sgdm_pkg::t_in_item                   i_data,
    output logic                                 o_stall,
    output logic                                 o_valid,
    output sgdm_pkg::t_out_item                  o_data,
    input  logic                                 i_stall,
    input  logic                                 i_cfg_we,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [sgdm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    sgdm_pkg::t_cfg r_cfg;
    sgdm_pkg::t_cfg n_cfg;

    logic                               w_busy;
    logic                               w_pipe_stall;
    logic                               w_rd_en;
    logic [AW-1:0]                      w_rd_addr;
    logic signed [sgdm_pkg::DATA_W-1:0] w_rd_data;
    logic                               w_wr_en;
    logic [AW-1:0]                      w_wr_addr;
    logic signed [sgdm_pkg::DATA_W-1:0] w_wr_data;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                sgdm_pkg::CFG_LEARN_RATE:   n_cfg.learn_rate      = i_cfg_data;
                sgdm_pkg::CFG_MOMENTUM:     n_cfg.momentum_factor = i_cfg_data;
                sgdm_pkg::CFG_DECAY:        n_cfg.decay_factor    = i_cfg_data;
                sgdm_pkg::CFG_USE_NESTEROV: n_cfg.use_nesterov    = i_cfg_data[0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sgdm_vel_mem #(
        .DEPTH (DEPTH)
    ) u_vel_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_busy    (w_busy)
    );

    sgdm_pipe #(
        .DEPTH (DEPTH)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid && !w_busy),
        .i_item    (i_data),
        .o_stall   (w_pipe_stall),
        .o_valid   (o_valid),
        .o_item    (o_data),
        .i_stall   (i_stall),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    assign o_stall = w_pipe_stall || w_busy;

endmodule

`default_nettype wire

// ----- hw/rtl/sgdm_vel_mem.sv -----
// velocity store: one write port, one registered read port, clearing sweep after reset
// depends on sgdm_pkg and sgd_momentum_update_top_defines.svh
`default_nettype none
`include "sgd_momentum_update_top_defines.svh"

module sgdm_vel_mem #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output logic signed [sgdm_pkg::DATA_W-1:0]  o_rd_data,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  logic signed [sgdm_pkg::DATA_W-1:0]  i_wr_data,
    output logic                                o_busy
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic signed [sgdm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [sgdm_pkg::DATA_W-1:0] r_rd_data;
    logic                               r_busy;
    logic [AW-1:0]                      r_clr_addr;

    logic                               w_we;
    logic [AW-1:0]                      w_wa;
    logic signed [sgdm_pkg::DATA_W-1:0] w_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // clearing sweep owns the write port until done
    assign w_we = r_busy || i_wr_en;
    assign w_wa = r_busy ? r_clr_addr : i_wr_addr;
    assign w_wd = r_busy ? '0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

    `SGDM_CHECK(a_no_wr_in_clear, i_clk, i_rst_n, r_busy, !i_wr_en)
    `SGDM_CHECK(a_clear_full_sweep, i_clk, i_rst_n, $fell(r_busy), $past(r_clr_addr) == AW'(DEPTH - 1))

endmodule

`default_nettype wire

// ----- hw/rtl/sgdm_pipe.sv -----
// eight-stage update datapath with per-stage valid bits and velocity forwarding
// depends on sgdm_pkg and sgd_momentum_update_top_defines.svh
`default_nettype none
`include "sgd_momentum_update_top_defines.svh"

module sgdm_pipe #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sgdm_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    input  sgdm_pkg::t_in_item                  i_item,
    output logic                                o_stall,
    output logic                                o_valid,
    output sgdm_pkg::t_out_item                 o_item,
    input  logic                                i_stall,
    output logic                                o_rd_en,
    output logic [$clog2(DEPTH)-1:0]            o_rd_addr,
    input  logic signed [sgdm_pkg::DATA_W-1:0]  i_rd_data,
    output logic                                o_wr_en,
    output logic [$clog2(DEPTH)-1:0]            o_wr_addr,
    output logic signed [sgdm_pkg::DATA_W-1:0]  o_wr_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned DW = sgdm_pkg::DATA_W;

    logic [8:1] w_en;
    logic [7:1] r_vld;
    logic       r_out_valid;

    sgdm_pkg::t_in_item  r_s1_item;

    logic [AW-1:0]        r_s2_addr;
    logic signed [DW-1:0] r_s2_dscl;
    logic signed [DW-1:0] r_s2_w;
    logic signed [DW-1:0] r_s2_grad;
    logic                 r_s2_first;

    logic [AW-1:0]        r_s3_addr;
    logic signed [DW-1:0] r_s3_g;
    logic signed [DW-1:0] r_s3_w;
    logic                 r_s3_first;

    logic [AW-1:0]        r_s4_addr;
    logic signed [DW-1:0] r_s4_v;
    logic signed [DW-1:0] r_s4_g;
    logic signed [DW-1:0] r_s4_w;

    logic signed [DW-1:0] r_s5_nscl;
    logic signed [DW-1:0] r_s5_v;
    logic signed [DW-1:0] r_s5_g;
    logic signed [DW-1:0] r_s5_w;

    logic signed [DW-1:0] r_s6_step;
    logic signed [DW-1:0] r_s6_v;
    logic signed [DW-1:0] r_s6_w;

    logic signed [DW-1:0] r_s7_lscl;
    logic signed [DW-1:0] r_s7_v;
    logic signed [DW-1:0] r_s7_w;

    sgdm_pkg::t_out_item  r_out_item;

    logic [AW-1:0]        n_s2_addr;
    logic signed [DW-1:0] n_s3_g;
    logic signed [DW-1:0] w_vold;
    logic signed [DW-1:0] n_s4_v;
    logic signed [DW-1:0] n_s6_step;
    sgdm_pkg::t_out_item  n_out;

    // stage k moves when it is empty or the stage after it moves
    always_comb begin
        w_en[8] = !r_out_valid || !i_stall;
        for (int k = 7; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[1];

    // element index folded onto the store depth
    if (DEPTH >= (2 ** sgdm_pkg::IDX_W)) begin : g_no_wrap
        assign n_s2_addr = AW'(r_s1_item.elem_index);
    end else begin : g_wrap
        localparam int unsigned RSH   = 20;
        localparam int unsigned RECIP = (2 ** RSH) / DEPTH;
        localparam logic [16:0] RECIP_C = 17'(RECIP);
        localparam logic [10:0] DEPTH_C = 11'(DEPTH);
        logic [26:0] w_prod;
        logic [6:0]  w_quot;
        logic [17:0] w_qd;
        logic [10:0] w_rem;
        assign w_prod = 27'(r_s1_item.elem_index) * 27'(RECIP_C);
        assign w_quot = w_prod[26:RSH];
        assign w_qd   = 18'(w_quot) * 18'(DEPTH_C);
        assign w_rem  = 11'(r_s1_item.elem_index) - w_qd[10:0];
        assign n_s2_addr = (w_rem >= DEPTH_C) ? AW'(w_rem - DEPTH_C) : AW'(w_rem);
    end

    assign n_s3_g = sgdm_pkg::f_add_sat(r_s2_grad, r_s2_dscl);

    // the item one stage ahead wrote on the edge this one read
    always_comb begin
        if (r_s3_first) begin
            w_vold = '0;
        end else if (r_vld[4] && (r_s4_addr == r_s3_addr)) begin
            w_vold = r_s4_v;
        end else begin
            w_vold = i_rd_data;
        end
    end

    assign n_s4_v = sgdm_pkg::f_add_sat(sgdm_pkg::f_scale(i_cfg.momentum_factor, w_vold), r_s3_g);

    assign n_s6_step = i_cfg.use_nesterov ? sgdm_pkg::f_add_sat(r_s5_nscl, r_s5_g) : r_s5_v;

    always_comb begin
        n_out.weight_out   = sgdm_pkg::f_sub_sat(r_s7_w, r_s7_lscl);
        n_out.velocity_out = r_s7_v;
    end

    assign o_rd_en   = w_en[3];
    assign o_rd_addr = r_s2_addr;
    assign o_wr_en   = w_en[4] && r_vld[3];
    assign o_wr_addr = r_s3_addr;
    assign o_wr_data = n_s4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= 7; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_en[8]) begin
                r_out_valid <= r_vld[7];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_item <= i_item;
        end
        if (w_en[2]) begin
            r_s2_addr  <= n_s2_addr;
            r_s2_dscl  <= sgdm_pkg::f_scale(i_cfg.decay_factor, r_s1_item.weight_in);
            r_s2_w     <= r_s1_item.weight_in;
            r_s2_grad  <= r_s1_item.grad_in;
            r_s2_first <= r_s1_item.first_use;
        end
        if (w_en[3]) begin
            r_s3_addr  <= r_s2_addr;
            r_s3_g     <= n_s3_g;
            r_s3_w     <= r_s2_w;
            r_s3_first <= r_s2_first;
        end
        if (w_en[4]) begin
            r_s4_addr <= r_s3_addr;
            r_s4_v    <= n_s4_v;
            r_s4_g    <= r_s3_g;
            r_s4_w    <= r_s3_w;
        end
        if (w_en[5]) begin
            r_s5_nscl <= sgdm_pkg::f_scale(i_cfg.momentum_factor, r_s4_v);
            r_s5_v    <= r_s4_v;
            r_s5_g    <= r_s4_g;
            r_s5_w    <= r_s4_w;
        end
        if (w_en[6]) begin
            r_s6_step <= n_s6_step;
            r_s6_v    <= r_s5_v;
            r_s6_w    <= r_s5_w;
        end
        if (w_en[7]) begin
            r_s7_lscl <= sgdm_pkg::f_scale(i_cfg.learn_rate, r_s6_step);
            r_s7_v    <= r_s6_v;
            r_s7_w    <= r_s6_w;
        end
        if (w_en[8]) begin
            r_out_item <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `SGDM_CHECK_NEXT(a_s7_holds_on_stall, i_clk, i_rst_n, r_out_valid && i_stall && r_vld[7], r_vld[7] && $stable(r_s7_w))

endmodule

`default_nettype wire
